// ----- design/nss_pkg.sv -----
`default_nettype none
package nss_pkg;

    localparam int CoordW     = 16;
    localparam int MaxPieces  = 9;
    localparam int PIdxW      = 4;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        COL_L,
        COL_R,
        COL_M,
        COL_F
    } t_col;

    typedef enum logic [1:0] {
        ROW_T,
        ROW_B,
        ROW_M,
        ROW_F
    } t_row;

    typedef struct packed {
        t_col col;
        t_row row;
    } t_piece;

    typedef struct packed {
        t_piece [MaxPieces-1:0] list;
        logic [PIdxW-1:0]       last_idx;
    } t_plan;

    // raw edges plus clamped extents
    typedef struct packed {
        logic [CoordW-1:0] dl;
        logic [CoordW-1:0] dt;
        logic [CoordW-1:0] dr;
        logic [CoordW-1:0] db;
        logic [CoordW-1:0] sl;
        logic [CoordW-1:0] st;
        logic [CoordW-1:0] sr;
        logic [CoordW-1:0] sb;
        logic [CoordW-1:0] w;
        logic [CoordW-1:0] h;
        logic [CoordW-1:0] sw;
        logic [CoordW-1:0] sh;
    } t_rect;

    typedef struct packed {
        t_rect             rect;
        logic [CoordW-1:0] lw;
        logic [CoordW-1:0] rw;
        logic [CoordW-1:0] th;
        logic [CoordW-1:0] bh;
        t_plan             plan;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

// ----- design/nss_queue.sv -----
`default_nettype none
module nss_queue #(
    parameter int DEPTH = nss_pkg::QueueDepth
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire nss_pkg::t_entry i_data,
    input  wire logic           i_pop,
    output nss_pkg::t_entry     o_data,
    output nss_pkg::t_q_stat    o_stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    nss_pkg::t_entry r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CntW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule
`default_nettype wire

// ----- design/nss_front.sv -----
`default_nettype none
module nss_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic signed [15:0]   i_dst_left,
    input  wire logic signed [15:0]   i_dst_top,
    input  wire logic signed [15:0]   i_dst_right,
    input  wire logic signed [15:0]   i_dst_bottom,
    input  wire logic signed [15:0]   i_src_left,
    input  wire logic signed [15:0]   i_src_top,
    input  wire logic signed [15:0]   i_src_right,
    input  wire logic signed [15:0]   i_src_bottom,
    input  wire nss_pkg::t_q_stat     i_q_stat,
    output logic                      o_push,
    output nss_pkg::t_entry           o_entry
);

    function automatic nss_pkg::t_plan make_plan(
        input logic eq_w,
        input logic eq_h,
        input logic wider,
        input logic taller
    );
        nss_pkg::t_plan          p;
        logic [nss_pkg::PIdxW-1:0] n;
        for (int i = 0; i < nss_pkg::MaxPieces; i++) begin
            p.list[i] = '{col: nss_pkg::COL_F, row: nss_pkg::ROW_F};
        end
        n = '0;
        if (eq_w && eq_h) begin
            n = n + 1'b1;
        end else if (eq_h) begin
            p.list[0] = '{col: nss_pkg::COL_L, row: nss_pkg::ROW_F};
            p.list[1] = '{col: nss_pkg::COL_R, row: nss_pkg::ROW_F};
            n = nss_pkg::PIdxW'(2);
            if (wider) begin
                p.list[2] = '{col: nss_pkg::COL_M, row: nss_pkg::ROW_F};
                n = nss_pkg::PIdxW'(3);
            end
        end else if (eq_w) begin
            p.list[0] = '{col: nss_pkg::COL_F, row: nss_pkg::ROW_T};
            p.list[1] = '{col: nss_pkg::COL_F, row: nss_pkg::ROW_B};
            n = nss_pkg::PIdxW'(2);
            if (taller) begin
                p.list[2] = '{col: nss_pkg::COL_F, row: nss_pkg::ROW_M};
                n = nss_pkg::PIdxW'(3);
            end
        end else begin
            p.list[0] = '{col: nss_pkg::COL_L, row: nss_pkg::ROW_T};
            p.list[1] = '{col: nss_pkg::COL_R, row: nss_pkg::ROW_T};
            p.list[2] = '{col: nss_pkg::COL_L, row: nss_pkg::ROW_B};
            p.list[3] = '{col: nss_pkg::COL_R, row: nss_pkg::ROW_B};
            n = nss_pkg::PIdxW'(4);
            if (wider) begin
                p.list[n]        = '{col: nss_pkg::COL_M, row: nss_pkg::ROW_T};
                p.list[n + 1'b1] = '{col: nss_pkg::COL_M, row: nss_pkg::ROW_B};
                n = n + nss_pkg::PIdxW'(2);
            end
            if (taller) begin
                p.list[n]        = '{col: nss_pkg::COL_L, row: nss_pkg::ROW_M};
                p.list[n + 1'b1] = '{col: nss_pkg::COL_R, row: nss_pkg::ROW_M};
                n = n + nss_pkg::PIdxW'(2);
            end
            if (wider && taller) begin
                p.list[n] = '{col: nss_pkg::COL_M, row: nss_pkg::ROW_M};
                n = n + 1'b1;
            end
        end
        p.last_idx = n - 1'b1;
        return p;
    endfunction

    logic           r_a_valid, n_a_valid;
    nss_pkg::t_rect r_a;
    nss_pkg::t_rect a_in;
    logic           accept;
    logic [15:0]    min_w, min_h;

    assign o_busy = r_a_valid && i_q_stat.full;
    assign accept = i_start && !o_busy;
    assign o_push = r_a_valid && !i_q_stat.full;

    // stage A: extents, negative spans clamp to zero
    always_comb begin
        a_in.dl = i_dst_left;
        a_in.dt = i_dst_top;
        a_in.dr = i_dst_right;
        a_in.db = i_dst_bottom;
        a_in.sl = i_src_left;
        a_in.st = i_src_top;
        a_in.sr = i_src_right;
        a_in.sb = i_src_bottom;
        a_in.w  = (i_dst_right > i_dst_left) ? 16'(i_dst_right - i_dst_left) : '0;
        a_in.h  = (i_dst_bottom > i_dst_top) ? 16'(i_dst_bottom - i_dst_top) : '0;
        a_in.sw = (i_src_right > i_src_left) ? 16'(i_src_right - i_src_left) : '0;
        a_in.sh = (i_src_bottom > i_src_top) ? 16'(i_src_bottom - i_src_top) : '0;
    end

    always_comb begin
        n_a_valid = r_a_valid;
        if (accept) begin
            n_a_valid = 1'b1;
        end else if (o_push) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= a_in;
        end
    end

    // classify: corner split and command list
    always_comb begin
        min_w         = (r_a.w < r_a.sw) ? r_a.w : r_a.sw;
        min_h         = (r_a.h < r_a.sh) ? r_a.h : r_a.sh;
        o_entry.rect  = r_a;
        o_entry.lw    = {1'b0, min_w[15:1]};
        o_entry.rw    = min_w - {1'b0, min_w[15:1]};
        o_entry.th    = {1'b0, min_h[15:1]};
        o_entry.bh    = min_h - {1'b0, min_h[15:1]};
        o_entry.plan  = make_plan(r_a.w == r_a.sw, r_a.h == r_a.sh,
                                  r_a.w > r_a.sw, r_a.h > r_a.sh);
    end

endmodule
`default_nettype wire

// ----- design/nss_back.sv -----
`default_nettype none
module nss_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire nss_pkg::t_q_stat    i_q_stat,
    input  wire nss_pkg::t_entry     i_entry,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic signed [15:0]       o_out_dst_x,
    output logic signed [15:0]       o_out_dst_y,
    output logic        [15:0]       o_out_dst_w,
    output logic        [15:0]       o_out_dst_h,
    output logic signed [15:0]       o_out_src_x,
    output logic signed [15:0]       o_out_src_y,
    output logic        [15:0]       o_out_src_w,
    output logic        [15:0]       o_out_src_h,
    output logic                     o_last_piece
);

    logic                      r_busy, n_busy;
    logic [nss_pkg::PIdxW-1:0] r_idx, n_idx;
    nss_pkg::t_entry           r_ent;
    logic                      r_valid;
    logic [15:0]               r_dx, r_dy, r_dw, r_dh, r_sx, r_sy, r_sw, r_sh;
    logic                      r_last;
    nss_pkg::t_piece           pc;
    logic                      last;
    logic [15:0]               dx, dy, dw, dh, sx, sy, sw, sh;

    assign last  = (r_idx == r_ent.plan.last_idx);
    assign o_pop = !i_q_stat.empty && (!r_busy || last);

    always_comb begin
        n_busy = o_pop || (r_busy && !last);
        n_idx  = r_idx;
        if (o_pop) begin
            n_idx = '0;
        end else if (r_busy) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_comb begin
        pc = r_ent.plan.list[r_idx];
        unique case (pc.col)
            nss_pkg::COL_L: begin
                dx = r_ent.rect.dl;
                dw = r_ent.lw;
                sx = r_ent.rect.sl;
                sw = r_ent.lw;
            end
            nss_pkg::COL_R: begin
                dx = r_ent.rect.dr - r_ent.rw;
                dw = r_ent.rw;
                sx = r_ent.rect.sr - r_ent.rw;
                sw = r_ent.rw;
            end
            nss_pkg::COL_M: begin
                dx = r_ent.rect.dl + r_ent.lw;
                dw = r_ent.rect.w - r_ent.rect.sw;
                sx = r_ent.rect.sl + r_ent.lw;
                sw = 16'd1;
            end
            default: begin
                dx = r_ent.rect.dl;
                dw = r_ent.rect.w;
                sx = r_ent.rect.sl;
                sw = r_ent.rect.w;
            end
        endcase
        unique case (pc.row)
            nss_pkg::ROW_T: begin
                dy = r_ent.rect.dt;
                dh = r_ent.th;
                sy = r_ent.rect.st;
                sh = r_ent.th;
            end
            nss_pkg::ROW_B: begin
                dy = r_ent.rect.db - r_ent.bh;
                dh = r_ent.bh;
                sy = r_ent.rect.sb - r_ent.bh;
                sh = r_ent.bh;
            end
            nss_pkg::ROW_M: begin
                dy = r_ent.rect.dt + r_ent.th;
                dh = r_ent.rect.h - r_ent.rect.sh;
                sy = r_ent.rect.st + r_ent.th;
                sh = 16'd1;
            end
            default: begin
                dy = r_ent.rect.dt;
                dh = r_ent.rect.h;
                sy = r_ent.rect.st;
                sh = r_ent.rect.h;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_idx   <= n_idx;
            r_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
        if (r_busy) begin
            r_dx   <= dx;
            r_dy   <= dy;
            r_dw   <= dw;
            r_dh   <= dh;
            r_sx   <= sx;
            r_sy   <= sy;
            r_sw   <= sw;
            r_sh   <= sh;
            r_last <= last;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_dst_x  = r_dx;
    assign o_out_dst_y  = r_dy;
    assign o_out_dst_w  = r_dw;
    assign o_out_dst_h  = r_dh;
    assign o_out_src_x  = r_sx;
    assign o_out_src_y  = r_sy;
    assign o_out_src_w  = r_sw;
    assign o_out_src_h  = r_sh;
    assign o_last_piece = r_last;

`ifndef NO_ASSERTIONS
    a_idx_in_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_ent.plan.last_idx))
        else $error("command index ran past end of plan");

    a_beats_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_piece) |=> o_valid)
        else $error("gap inside one rectangle pair's commands");

    a_no_idle_with_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_q_stat.empty) |=> r_busy)
        else $error("back end idle while queue holds work");
`endif

endmodule
`default_nettype wire

// ----- design/nine_slice_stretch_planner.sv -----
`default_nettype none
// Nine-slice stretch planner. A rectangle pair is taken at a clock edge with
// i_start high and o_busy low; it yields 1, 2, 3, 4, 6 or 9 blit commands, one
// beat per cycle within a pair on the o_* ports, each beat marked by o_valid
// for a single cycle and the pair's final beat by o_last_piece. The receiver
// cannot stall the block, so beats must be taken as they appear. A pair passes
// the front-end register, the queue and the back end's entry register before
// its first beat. The back end's single command sequencer sets throughput,
// taking the next pair with the current one's last command; the front end and
// a QUEUE_DEPTH-entry queue hold pairs; o_busy rises only when both are full.
module nine_slice_stretch_planner #(
    parameter int QUEUE_DEPTH = nss_pkg::QueueDepth
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output logic                     o_busy,
    input  wire logic signed [15:0]  i_dst_left,
    input  wire logic signed [15:0]  i_dst_top,
    input  wire logic signed [15:0]  i_dst_right,
    input  wire logic signed [15:0]  i_dst_bottom,
    input  wire logic signed [15:0]  i_src_left,
    input  wire logic signed [15:0]  i_src_top,
    input  wire logic signed [15:0]  i_src_right,
    input  wire logic signed [15:0]  i_src_bottom,
    output logic                     o_valid,
    output logic signed [15:0]       o_out_dst_x,
    output logic signed [15:0]       o_out_dst_y,
    output logic        [15:0]       o_out_dst_w,
    output logic        [15:0]       o_out_dst_h,
    output logic signed [15:0]       o_out_src_x,
    output logic signed [15:0]       o_out_src_y,
    output logic        [15:0]       o_out_src_w,
    output logic        [15:0]       o_out_src_h,
    output logic                     o_last_piece
);

    nss_pkg::t_q_stat q_stat;
    nss_pkg::t_entry  push_entry;
    nss_pkg::t_entry  head_entry;
    logic             push;
    logic             pop;

    nss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_dst_left   (i_dst_left),
        .i_dst_top    (i_dst_top),
        .i_dst_right  (i_dst_right),
        .i_dst_bottom (i_dst_bottom),
        .i_src_left   (i_src_left),
        .i_src_top    (i_src_top),
        .i_src_right  (i_src_right),
        .i_src_bottom (i_src_bottom),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    nss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_stat  (q_stat)
    );

    nss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_entry      (head_entry),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_out_dst_x  (o_out_dst_x),
        .o_out_dst_y  (o_out_dst_y),
        .o_out_dst_w  (o_out_dst_w),
        .o_out_dst_h  (o_out_dst_h),
        .o_out_src_x  (o_out_src_x),
        .o_out_src_y  (o_out_src_y),
        .o_out_src_w  (o_out_src_w),
        .o_out_src_h  (o_out_src_h),
        .o_last_piece (o_last_piece)
    );

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [15:0] dl;
        logic [15:0] dt;
        logic [15:0] dr;
        logic [15:0] db;
        logic [15:0] sl;
        logic [15:0] st;
        logic [15:0] sr;
        logic [15:0] sb;
    } t_rect_pair;

    typedef struct packed {
        logic [15:0] dst_x;
        logic [15:0] dst_y;
        logic [15:0] dst_w;
        logic [15:0] dst_h;
        logic [15:0] src_x;
        logic [15:0] src_y;
        logic [15:0] src_w;
        logic [15:0] src_h;
        logic        last;
    } t_blit;

    class blit_scoreboard;
        t_blit pending_blits[$];
        int    pairs_seen;
        int    beats_seen;
        int    mismatches;

        function string fmt(t_blit b);
            return $sformatf("dst %0d,%0d %0dx%0d src %0d,%0d %0dx%0d last %0b",
                             $signed(b.dst_x), $signed(b.dst_y), b.dst_w, b.dst_h,
                             $signed(b.src_x), $signed(b.src_y), b.src_w, b.src_h,
                             b.last);
        endfunction

        function int span(int lo, int hi);
            return (hi > lo) ? hi - lo : 0;
        endfunction

        function void add_blit(int dx, int dy, int dw, int dh,
                               int sx, int sy, int sw, int sh);
            t_blit b;
            b.dst_x = 16'(dx);
            b.dst_y = 16'(dy);
            b.dst_w = 16'(dw);
            b.dst_h = 16'(dh);
            b.src_x = 16'(sx);
            b.src_y = 16'(sy);
            b.src_w = 16'(sw);
            b.src_h = 16'(sh);
            b.last  = 1'b0;
            pending_blits.push_back(b);
        endfunction

        // plans the blits of one accepted rectangle pair
        function void note_pair(t_rect_pair p);
            int dx0, dy0, dx1, dy1, sx0, sy0, sx1, sy1;
            int w, h, sw, sh, lw, rw, th, bh;
            bit wider, taller;
            dx0 = int'($signed(p.dl));
            dy0 = int'($signed(p.dt));
            dx1 = int'($signed(p.dr));
            dy1 = int'($signed(p.db));
            sx0 = int'($signed(p.sl));
            sy0 = int'($signed(p.st));
            sx1 = int'($signed(p.sr));
            sy1 = int'($signed(p.sb));
            w   = span(dx0, dx1);
            h   = span(dy0, dy1);
            sw  = span(sx0, sx1);
            sh  = span(sy0, sy1);
            wider  = w > sw;
            taller = h > sh;
            pairs_seen++;
            if (w == sw && h == sh) begin
                add_blit(dx0, dy0, w, h, sx0, sy0, w, h);
            end else begin
                rw = (w < sw) ? w : sw;
                lw = rw / 2;
                rw = rw - lw;
                bh = (h < sh) ? h : sh;
                th = bh / 2;
                bh = bh - th;
                if (h == sh) begin
                    add_blit(dx0, dy0, lw, h, sx0, sy0, lw, h);
                    add_blit(dx1 - rw, dy0, rw, h, sx1 - rw, sy0, rw, h);
                    if (wider)
                        add_blit(dx0 + lw, dy0, w - sw, h, sx0 + lw, sy0, 1, h);
                end else if (w == sw) begin
                    add_blit(dx0, dy0, w, th, sx0, sy0, w, th);
                    add_blit(dx0, dy1 - bh, w, bh, sx0, sy1 - bh, w, bh);
                    if (taller)
                        add_blit(dx0, dy0 + th, w, h - sh, sx0, sy0 + th, w, 1);
                end else begin
                    add_blit(dx0, dy0, lw, th, sx0, sy0, lw, th);
                    add_blit(dx1 - rw, dy0, rw, th, sx1 - rw, sy0, rw, th);
                    add_blit(dx0, dy1 - bh, lw, bh, sx0, sy1 - bh, lw, bh);
                    add_blit(dx1 - rw, dy1 - bh, rw, bh, sx1 - rw, sy1 - bh, rw, bh);
                    if (wider) begin
                        add_blit(dx0 + lw, dy0, w - sw, th, sx0 + lw, sy0, 1, th);
                        add_blit(dx0 + lw, dy1 - bh, w - sw, bh,
                                 sx0 + lw, sy1 - bh, 1, bh);
                    end
                    if (taller) begin
                        add_blit(dx0, dy0 + th, lw, h - sh, sx0, sy0 + th, lw, 1);
                        add_blit(dx1 - rw, dy0 + th, rw, h - sh,
                                 sx1 - rw, sy0 + th, rw, 1);
                    end
                    if (wider && taller)
                        add_blit(dx0 + lw, dy0 + th, w - sw, h - sh,
                                 sx0 + lw, sy0 + th, 1, 1);
                end
            end
            pending_blits[pending_blits.size() - 1].last = 1'b1;
        endfunction

        function void check_beat(t_blit got);
            t_blit want;
            beats_seen++;
            if (pending_blits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected blit beat: %s", fmt(got));
            end else begin
                want = pending_blits.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("blit mismatch at beat %0d", beats_seen);
                        $display("  expected %s", fmt(want));
                        $display("  actual   %s", fmt(got));
                    end
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [15:0] i_dst_left;
    logic signed [15:0] i_dst_top;
    logic signed [15:0] i_dst_right;
    logic signed [15:0] i_dst_bottom;
    logic signed [15:0] i_src_left;
    logic signed [15:0] i_src_top;
    logic signed [15:0] i_src_right;
    logic signed [15:0] i_src_bottom;
    logic               o_valid;
    logic signed [15:0] o_out_dst_x;
    logic signed [15:0] o_out_dst_y;
    logic        [15:0] o_out_dst_w;
    logic        [15:0] o_out_dst_h;
    logic signed [15:0] o_out_src_x;
    logic signed [15:0] o_out_src_y;
    logic        [15:0] o_out_src_w;
    logic        [15:0] o_out_src_h;
    logic               o_last_piece;

    blit_scoreboard sb_blits = new();
    int             burst_left;

    nine_slice_stretch_planner u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_dst_left   (i_dst_left),
        .i_dst_top    (i_dst_top),
        .i_dst_right  (i_dst_right),
        .i_dst_bottom (i_dst_bottom),
        .i_src_left   (i_src_left),
        .i_src_top    (i_src_top),
        .i_src_right  (i_src_right),
        .i_src_bottom (i_src_bottom),
        .o_valid      (o_valid),
        .o_out_dst_x  (o_out_dst_x),
        .o_out_dst_y  (o_out_dst_y),
        .o_out_dst_w  (o_out_dst_w),
        .o_out_dst_h  (o_out_dst_h),
        .o_out_src_x  (o_out_src_x),
        .o_out_src_y  (o_out_src_y),
        .o_out_src_w  (o_out_src_w),
        .o_out_src_h  (o_out_src_h),
        .o_last_piece (o_last_piece)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_blit got;
        if (i_rst_n && o_valid) begin
            got.dst_x = o_out_dst_x;
            got.dst_y = o_out_dst_y;
            got.dst_w = o_out_dst_w;
            got.dst_h = o_out_dst_h;
            got.src_x = o_out_src_x;
            got.src_y = o_out_src_y;
            got.src_w = o_out_src_w;
            got.src_h = o_out_src_h;
            got.last  = o_last_piece;
            sb_blits.check_beat(got);
        end
    end

    function t_rect_pair mk_pair(int dl, int dt, int dr, int db,
                                 int sl, int st, int sr, int sb);
        t_rect_pair p;
        p.dl = 16'(dl);
        p.dt = 16'(dt);
        p.dr = 16'(dr);
        p.db = 16'(db);
        p.sl = 16'(sl);
        p.st = 16'(st);
        p.sr = 16'(sr);
        p.sb = 16'(sb);
        return p;
    endfunction

    // random coordinate that leaves room for an extent of ext
    function int rand_base(int ext);
        return -32768 + int'($urandom_range(0, 65535 - ext));
    endfunction

    function t_rect_pair rand_pair();
        int kind, w, h, sw, sh, dl, dt, sl, st;
        kind = $urandom_range(0, 11);
        if (kind == 11)
            return t_rect_pair'({$urandom, $urandom, $urandom, $urandom});
        if (kind == 10) begin
            w  = $urandom_range(0, 65535);
            h  = $urandom_range(0, 65535);
            sw = $urandom_range(0, 65535);
            sh = $urandom_range(0, 65535);
        end else begin
            w  = $urandom_range(0, 48);
            h  = $urandom_range(0, 48);
            sw = $urandom_range(0, 48);
            sh = $urandom_range(0, 48);
        end
        case (kind)
            0:       begin sw = w; sh = h; end
            1, 2:    sh = h;
            3, 4:    sw = w;
            default: ;
        endcase
        dl = rand_base(w);
        dt = rand_base(h);
        sl = rand_base(sw);
        st = rand_base(sh);
        if (kind == 9)
            return mk_pair(dl + w, dt + h, dl, dt, sl, st, sl + sw, st + sh);
        return mk_pair(dl, dt, dl + w, dt + h, sl, st, sl + sw, st + sh);
    endfunction

    task automatic drive_pair(input t_rect_pair p);
        if (burst_left == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        i_start      <= 1'b1;
        i_dst_left   <= p.dl;
        i_dst_top    <= p.dt;
        i_dst_right  <= p.dr;
        i_dst_bottom <= p.db;
        i_src_left   <= p.sl;
        i_src_top    <= p.st;
        i_src_right  <= p.sr;
        i_src_bottom <= p.sb;
        do @(posedge i_clk); while (o_busy);
        sb_blits.note_pair(p);
    endtask

    initial begin
        t_rect_pair directed_q[$];
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_dst_left   = '0;
        i_dst_top    = '0;
        i_dst_right  = '0;
        i_dst_bottom = '0;
        i_src_left   = '0;
        i_src_top    = '0;
        i_src_right  = '0;
        i_src_bottom = '0;
        burst_left   = 0;

        directed_q.push_back(mk_pair(10, 20, 30, 40, 100, 200, 120, 220));
        directed_q.push_back(mk_pair(0, 0, 50, 10, 0, 0, 7, 10));
        directed_q.push_back(mk_pair(5, 5, 8, 15, 0, 0, 20, 10));
        directed_q.push_back(mk_pair(0, 0, 10, 40, 3, 3, 13, 8));
        directed_q.push_back(mk_pair(0, 0, 10, 3, 0, 0, 10, 9));
        directed_q.push_back(mk_pair(-100, -50, 100, 60, 10, 10, 15, 19));
        directed_q.push_back(mk_pair(0, 0, 40, 4, 0, 0, 9, 12));
        directed_q.push_back(mk_pair(0, 0, 4, 40, 0, 0, 11, 9));
        directed_q.push_back(mk_pair(0, 0, 5, 6, 0, 0, 30, 31));
        // inverted edges clamp to zero extent
        directed_q.push_back(mk_pair(50, 50, 10, 10, 0, 0, 6, 6));
        directed_q.push_back(mk_pair(0, 0, 20, 20, 30, 30, -5, -5));
        directed_q.push_back(mk_pair(7, 7, 1, 1, 9, 9, 2, 2));
        directed_q.push_back(mk_pair(3, 3, 3, 20, 0, 0, 5, 5));
        directed_q.push_back(mk_pair(0, 10, 30, 5, 0, 20, 4, 1));
        directed_q.push_back(mk_pair(-1, -1, 0, 0, -1, -1, -1, -1));
        directed_q.push_back(mk_pair(0, 0, 2, 2, 0, 0, 1, 1));
        directed_q.push_back(mk_pair(0, 0, 100, 100, 0, 0, 7, 5));
        // full-range coordinates
        directed_q.push_back(mk_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
        directed_q.push_back(mk_pair(-32768, -32768, 32767, 32767,
                                     -32768, -32768, 32767, 32767));
        directed_q.push_back(mk_pair(0, 0, 3, 3, -32768, -32768, 32767, 32767));
        directed_q.push_back(mk_pair(32767, 32767, -32768, -32768,
                                     32767, 32767, -32768, -32768));
        directed_q.push_back(mk_pair(32767, -32768, -32768, 32767,
                                     -32768, 32767, 32767, -32768));
        directed_q.push_back(mk_pair(-32768, 0, 32767, 1, -32768, 0, 32767, 1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[i])
            drive_pair(directed_q[i]);
        repeat (157)
            drive_pair(rand_pair());
        i_start <= 1'b0;

        while (sb_blits.pending_blits.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("%0d rectangle pairs (%0d directed, rest random) sent, %0d blit beats checked",
                 sb_blits.pairs_seen, directed_q.size(), sb_blits.beats_seen);
        $display("%0d blit mismatches", sb_blits.mismatches);
        if (sb_blits.mismatches == 0) begin
            $display("nine_slice_stretch_planner verification clean");
        end else begin
            $display("nine_slice_stretch_planner verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d blits outstanding", sb_blits.pending_blits.size());
        $display("nine_slice_stretch_planner verification failed");
        $finish;
    end

endmodule

// ----- nine_slice_stretch_planner.f -----
design/nss_pkg.sv
design/nss_queue.sv
design/nss_front.sv
design/nss_back.sv
design/nine_slice_stretch_planner.sv
tb/sv/tb_top.sv
